>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Clock and reset are taken from the names clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define BSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included
`define BSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> src/bsa_pkg.sv
// Package for the bucket statistics aggregator: widths, codes, bucket record.
// No dependencies.
`default_nettype none
package bsa_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 64;
  localparam int SQ_W      = 64;
  localparam int VAR_W     = 63;
  localparam int LEN_W     = 13;
  localparam int CNT_W     = 17;
  localparam int DIV_STEPS = 64;

  // Configuration register indexes
  localparam logic CFG_BUCKET_LEN   = 1'b0;
  localparam logic CFG_COUNTER_MODE = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 32'sh80000000;
  localparam logic [VAR_W-1:0]           VAR_MAX  = {VAR_W{1'b1}};

  // One closed bucket, handed from the accumulator to the finishing unit
  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]            sq;
    logic signed [SAMPLE_W-1:0] min_v;
    logic signed [SAMPLE_W-1:0] max_v;
    logic [CNT_W-1:0]           cnt;
    logic                       last;
  } bucket_t;

endpackage
`default_nettype wire

>>> src/bsa_if.sv
// Valid/ready channel interfaces for samples and bucket results.
// Depends on nothing.
`default_nettype none
interface bsa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               range_end;
  modport source (output valid, output sample, output range_end, input ready);
  modport sink   (input valid, input sample, input range_end, output ready);
endinterface

interface bsa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] average;
  logic signed [31:0] minimum;
  logic signed [31:0] maximum;
  logic [62:0]        variance;
  logic [12:0]        count;
  logic               final_res;
  modport source (output valid, output average, output minimum, output maximum,
                  output variance, output count, output final_res, input ready);
  modport sink   (input valid, input average, input minimum, input maximum,
                  input variance, input count, input final_res, output ready);
endinterface
`default_nettype wire

>>> src/bsa_front.sv
// Accumulator front: takes samples, keeps sum, square sum, min, max, count.
// Depends on bsa_pkg and bsa_in_if.
`default_nettype none
module bsa_front #(
  parameter int MAX_BUCKET = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  bsa_in_if.sink                        in_ch,
  input  wire logic [bsa_pkg::LEN_W-1:0] bucket_len,
  input  wire logic                     counter_mode,
  output logic                          push,
  output bsa_pkg::bucket_t              push_data,
  input  wire logic                     full
);

  logic                                 s1_v_r, s2_v_r;
  logic signed [bsa_pkg::SAMPLE_W-1:0]  v1_r;
  logic                                 last1_r;
  logic [bsa_pkg::SQ_W-1:0]             sq2_r;
  logic                                 close2_r;
  bsa_pkg::bucket_t                     snap2_r;

  logic signed [bsa_pkg::SUM_W-1:0]     sum_r;
  logic [bsa_pkg::SQ_W-1:0]             sqsum_r;
  logic signed [bsa_pkg::SAMPLE_W-1:0]  min_r, max_r;
  logic [bsa_pkg::CNT_W-1:0]            cnt_r;
  logic [bsa_pkg::SAMPLE_W-1:0]         prev_r;
  logic                                 start_r;

  logic                                 acc, s1_adv, s2_adv, close1;
  logic signed [bsa_pkg::SAMPLE_W-1:0]  v_in;
  logic [bsa_pkg::CNT_W-1:0]            len_x, len_eff, max_len, cnt_nxt;
  logic signed [bsa_pkg::SUM_W-1:0]     sum_nxt;
  logic signed [bsa_pkg::SAMPLE_W-1:0]  min_nxt, max_nxt;
  logic [bsa_pkg::SAMPLE_W-1:0]         mag1;
  logic [bsa_pkg::SQ_W-1:0]             sq1, sq_sum;
  logic [bsa_pkg::SQ_W:0]               sq_add;

  assign s2_adv      = s2_v_r && (!close2_r || !full);
  assign s1_adv      = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // first sample of a range is always taken raw
  assign v_in = (counter_mode && !start_r) ? in_ch.sample - $signed(prev_r) : in_ch.sample;

  assign len_x   = bsa_pkg::CNT_W'(bucket_len);
  assign max_len = bsa_pkg::CNT_W'(MAX_BUCKET);
  always_comb begin
    priority if (len_x == '0) len_eff = bsa_pkg::CNT_W'(1);
    else if (len_x > max_len) len_eff = max_len;
    else                      len_eff = len_x;
  end

  assign cnt_nxt = cnt_r + bsa_pkg::CNT_W'(1);
  assign close1  = (cnt_nxt >= len_eff) || last1_r;
  assign sum_nxt = sum_r + bsa_pkg::SUM_W'(v1_r);
  assign min_nxt = (v1_r < min_r) ? v1_r : min_r;
  assign max_nxt = (v1_r > max_r) ? v1_r : max_r;
  assign mag1    = v1_r[bsa_pkg::SAMPLE_W-1] ? (~v1_r + 1'b1) : v1_r;
  assign sq1     = mag1 * mag1;

  assign sq_add  = {1'b0, sqsum_r} + {1'b0, sq2_r};
  assign sq_sum  = sq_add[bsa_pkg::SQ_W] ? '1 : sq_add[bsa_pkg::SQ_W-1:0];
  assign push    = s2_adv && close2_r;

  always_comb begin
    push_data    = snap2_r;
    push_data.sq = sq_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      sum_r   <= '0;
      sqsum_r <= '0;
      min_r   <= bsa_pkg::MIN_INIT;
      max_r   <= bsa_pkg::MAX_INIT;
      cnt_r   <= '0;
      prev_r  <= '0;
      start_r <= 1'b1;
    end else begin
      if (acc) begin
        prev_r  <= in_ch.sample;
        start_r <= in_ch.range_end;
      end
      if (acc)         s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv)      s2_v_r <= 1'b1;
      else if (s2_adv) s2_v_r <= 1'b0;
      if (s1_adv) begin
        if (close1) begin
          sum_r <= '0;
          min_r <= bsa_pkg::MIN_INIT;
          max_r <= bsa_pkg::MAX_INIT;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          min_r <= min_nxt;
          max_r <= max_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      // square sum lags one stage behind the other totals
      if (s2_adv) sqsum_r <= close2_r ? '0 : sq_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      v1_r    <= v_in;
      last1_r <= in_ch.range_end;
    end
    if (s1_adv) begin
      sq2_r         <= sq1;
      close2_r      <= close1;
      snap2_r.sum   <= sum_nxt;
      snap2_r.sq    <= '0;
      snap2_r.min_v <= min_nxt;
      snap2_r.max_v <= max_nxt;
      snap2_r.cnt   <= cnt_nxt;
      snap2_r.last  <= last1_r;
    end
  end

endmodule
`default_nettype wire

>>> src/bsa_fifo.sv
// Two-entry queue of closed buckets between accumulator and finishing unit.
// Depends on bsa_pkg.
`default_nettype none
module bsa_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bsa_pkg::bucket_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output bsa_pkg::bucket_t       pop_data,
  output logic                   empty
);

  bsa_pkg::bucket_t ent_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> src/bsa_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on bsa_pkg.
`default_nettype none
module bsa_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [63:0]               dividend,
  input  wire logic [bsa_pkg::CNT_W-1:0] divisor,
  output logic                           done,
  output logic [63:0]                    quot
);

  logic [63:0]               q_r;
  logic [bsa_pkg::CNT_W-1:0] rem_r, dsr_r;
  logic [5:0]                step_r;
  logic                      run_r, done_r;
  logic [bsa_pkg::CNT_W:0]   rem_sh, rem_sub;
  logic                      ge;

  assign rem_sh  = {rem_r, q_r[63]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign done    = done_r;
  assign quot    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 6'd1;
        if (step_r == 6'(bsa_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[62:0], ge};
      rem_r <= ge ? rem_sub[bsa_pkg::CNT_W-1:0] : rem_sh[bsa_pkg::CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> src/bsa_back.sv
// Finishing unit: average, product check and variance for each closed bucket.
// Depends on bsa_pkg, bsa_out_if and bsa_div.
`default_nettype none
module bsa_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsa_pkg::bucket_t  head,
  input  wire logic              empty,
  output logic                   pop,
  bsa_out_if.source              out_ch
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_DIVQ = 8'b00000010,
    ST_MULL = 8'b00000100,
    ST_MULH = 8'b00001000,
    ST_PSUM = 8'b00010000,
    ST_DIFF = 8'b00100000,
    ST_DIVV = 8'b01000000,
    ST_OUT  = 8'b10000000
  } state_t;

  state_t                state_r, state_nxt;
  bsa_pkg::bucket_t      ent_r;
  logic [63:0]           amag_r, amag_nxt;
  logic [31:0]           qmag_r;
  logic signed [63:0]    q_r;
  logic [63:0]           pl_r, ph_r, p_r, d_nxt;
  logic                  ovf_r;
  logic [bsa_pkg::VAR_W-1:0] var_r;
  logic [95:0]           p96;

  logic                      div_start, div_done;
  logic [63:0]               div_dvd, div_q;
  logic [bsa_pkg::CNT_W-1:0] div_dsr;

  assign pop      = (state_r == ST_IDLE) && !empty;
  assign amag_nxt = head.sum[63] ? 64'(-head.sum) : 64'(head.sum);
  assign p96      = {ph_r, 32'b0} + {32'b0, pl_r};
  assign d_nxt    = (!ovf_r && ent_r.sq >= p_r) ? ent_r.sq - p_r : '0;

  assign div_start = pop || (state_r == ST_DIFF);
  assign div_dvd   = (state_r == ST_DIFF) ? d_nxt : amag_nxt;
  assign div_dsr   = (state_r == ST_DIFF) ? ent_r.cnt - bsa_pkg::CNT_W'(1) : head.cnt;

  bsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!empty) state_nxt = ST_DIVQ;
      ST_DIVQ: begin
        if (div_done)
          state_nxt = (ent_r.cnt == bsa_pkg::CNT_W'(1)) ? ST_OUT : ST_MULL;
      end
      ST_MULL: state_nxt = ST_MULH;
      ST_MULH: state_nxt = ST_PSUM;
      ST_PSUM: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_DIVV;
      ST_DIVV: if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r  <= head;
      amag_r <= amag_nxt;
    end
    if (state_r == ST_DIVQ && div_done) begin
      qmag_r <= div_q[31:0];
      q_r    <= ent_r.sum[63] ? -$signed(div_q) : $signed(div_q);
      var_r  <= '0;
    end
    if (state_r == ST_MULL) pl_r <= amag_r[31:0] * qmag_r;
    if (state_r == ST_MULH) ph_r <= amag_r[63:32] * qmag_r;
    if (state_r == ST_PSUM) begin
      ovf_r <= |p96[95:64];
      p_r   <= p96[63:0];
    end
    if (state_r == ST_DIVV && div_done)
      var_r <= div_q[63] ? bsa_pkg::VAR_MAX : div_q[bsa_pkg::VAR_W-1:0];
  end

  assign out_ch.valid     = state_r == ST_OUT;
  assign out_ch.average   = q_r[31:0];
  assign out_ch.minimum   = ent_r.min_v;
  assign out_ch.maximum   = ent_r.max_v;
  assign out_ch.variance  = var_r;
  assign out_ch.count     = ent_r.cnt[12:0];
  assign out_ch.final_res = ent_r.last;

endmodule
`default_nettype wire

>>> src/bucket_statistics_aggregator.sv
// Bucket statistics: average, min, max and sample variance over buckets.
// Front accepts one sample per cycle unless a closed bucket meets a full queue;
// samples pass stages s1 and s2 before the push. The finishing unit makes one
// 64-step divider pass for a one-sample bucket, else two; the 2-entry queue
// lets accumulation run ahead of it. Synchronous active-low reset, no sweep.
// Depends on bsa_pkg, bsa_if, bsa_front, bsa_fifo, bsa_back.
`default_nettype none
module bucket_statistics_aggregator #(
  parameter int MAX_BUCKET = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  bsa_in_if.sink                        in_ch,
  bsa_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [bsa_pkg::LEN_W-1:0] cfg_data
);

  logic [bsa_pkg::LEN_W-1:0] bucket_len_r;
  logic                      counter_mode_r;
  logic                      push, full, pop, empty;
  bsa_pkg::bucket_t          push_data, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_len_r   <= bsa_pkg::LEN_W'(1);
      counter_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsa_pkg::CFG_BUCKET_LEN:   bucket_len_r   <= cfg_data;
        bsa_pkg::CFG_COUNTER_MODE: counter_mode_r <= cfg_data[0];
      endcase
    end
  end

  bsa_front #(.MAX_BUCKET(MAX_BUCKET)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .bucket_len   (bucket_len_r),
    .counter_mode (counter_mode_r),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  bsa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  bsa_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

>>> src/bsa_checker.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_average,
  input wire logic [31:0] out_minimum,
  input wire logic [31:0] out_maximum,
  input wire logic [62:0] out_variance,
  input wire logic [12:0] out_count
);

  `BSA_ASSERT_ALWAYS(a_no_result_after_reset, !rst_n |=> !out_valid, "result right after reset")
  `BSA_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
  `BSA_ASSERT(a_payload_holds, out_valid && !out_ready |=> $stable(out_variance) && $stable(out_average), "stalled result changed")
  `BSA_ASSERT(a_min_le_max, out_valid |-> $signed(out_minimum) <= $signed(out_maximum), "minimum above maximum")
  `BSA_ASSERT(a_single_item, out_valid && out_count == 13'd1 |-> out_variance == 63'd0 && out_minimum == out_maximum && out_average == out_minimum, "single-sample bucket inconsistent")

endmodule

bind bucket_statistics_aggregator bsa_checker u_bsa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_average  (out_ch.average),
  .out_minimum  (out_ch.minimum),
  .out_maximum  (out_ch.maximum),
  .out_variance (out_ch.variance),
  .out_count    (out_ch.count)
);
`default_nettype wire
